[rtl/mvdi_pkg.sv]
// Shared types and constants for the vertex dedup indexer.
`timescale 1ns / 1ps
`default_nettype none
package mvdi_pkg;
   localparam int FIELD_BITS  = 20;
   localparam int VIDX_BITS   = 12;
   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int COUNT_BITS  = ADDR_BITS + 1;
   localparam int HASH_DEPTH  = 4096;
   localparam int HASH_BITS   = $clog2(HASH_DEPTH);

   localparam logic [COUNT_BITS-1:0] TABLE_COUNT = COUNT_BITS'(TABLE_DEPTH);
   localparam logic [COUNT_BITS-1:0] LINK_END    = TABLE_COUNT;

   typedef struct packed {
      logic [FIELD_BITS-1:0] pos;
      logic [FIELD_BITS-1:0] tex;
      logic [FIELD_BITS-1:0] nrm;
   } triple_type;

   typedef struct packed {
      triple_type            key;
      logic [COUNT_BITS-1:0] next;
   } entry_type;

   typedef struct packed {
      logic [VIDX_BITS-1:0] vertex_index;
      logic                 is_new;
      triple_type           key;
      logic                 table_full;
      logic                 last_corner;
   } corner_rsp_type;

   function automatic logic [HASH_BITS-1:0] hash_triple(input triple_type t);
      logic [59:0] w;
      w = t;
      return w[11:0] ^ w[23:12] ^ w[35:24] ^ w[47:36] ^ w[59:48];
   endfunction
endpackage
`default_nettype wire

[rtl/mvdi_table.sv]
// Triple store with chain links and hash bucket heads, registered-read memories.
`timescale 1ns / 1ps
`default_nettype none
module mvdi_table (
   input  wire logic                            clock,
   input  wire logic                            rd_en,
   input  wire logic [mvdi_pkg::ADDR_BITS-1:0]  rd_addr,
   output mvdi_pkg::entry_type                  rd_entry,
   input  wire logic                            hd_en,
   input  wire logic [mvdi_pkg::HASH_BITS-1:0]  hd_addr,
   output logic [mvdi_pkg::COUNT_BITS-1:0]      hd_data,
   input  wire logic                            wr_en,
   input  wire logic [mvdi_pkg::ADDR_BITS-1:0]  wr_addr,
   input  wire mvdi_pkg::entry_type             wr_entry,
   input  wire logic                            hw_en,
   input  wire logic [mvdi_pkg::HASH_BITS-1:0]  hw_addr,
   input  wire logic [mvdi_pkg::COUNT_BITS-1:0] hw_data
);
   import mvdi_pkg::*;
   entry_type             entry_mem [TABLE_DEPTH];
   logic [COUNT_BITS-1:0] head_mem  [HASH_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) entry_mem[wr_addr] <= wr_entry;
      if (rd_en) rd_entry <= entry_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (hw_en) head_mem[hw_addr] <= hw_data;
      if (hd_en) hd_data <= head_mem[hd_addr];
   end
endmodule
`default_nettype wire

[rtl/mesh_vertex_dedup_indexer.sv]
// Top level: face sequencing, hashed chain lookup and insert, result register.
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/ready    | pos/tex/nrm a..d
//  rsp     | out | rsp_valid/ready    | vertex_index, is_new, out_*, flags
// One face at a time: accept in idle, then per corner a head read, head decode, a walk
// step per chain entry walked, and output. Chain links always point to older entries.
// Reset starts a pass that writes every bucket head to the end marker; req_ready stays
// low during it. req_ready is high only between faces.
// A beat not yet taken on rsp holds the next corner in its output state.
`timescale 1ns / 1ps
`default_nettype none
module mesh_vertex_dedup_indexer (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  wire logic [19:0] req_pos_a, input wire logic [19:0] req_tex_a,
   input  wire logic [19:0] req_nrm_a,
   input  wire logic [19:0] req_pos_b, input wire logic [19:0] req_tex_b,
   input  wire logic [19:0] req_nrm_b,
   input  wire logic [19:0] req_pos_c, input wire logic [19:0] req_tex_c,
   input  wire logic [19:0] req_nrm_c,
   input  wire logic [19:0] req_pos_d, input wire logic [19:0] req_tex_d,
   input  wire logic [19:0] req_nrm_d,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output logic [11:0] rsp_vertex_index,
   output logic      rsp_is_new,
   output logic [19:0] rsp_out_pos,
   output logic [19:0] rsp_out_tex,
   output logic [19:0] rsp_out_nrm,
   output logic      rsp_table_full,
   output logic      rsp_last_corner
);
   import mvdi_pkg::*;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001, S_IDLE = 6'b000010, S_ISSUE = 6'b000100,
      S_HEAD  = 6'b001000, S_WALK = 6'b010000, S_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   triple_type corner_ff [4];
   logic [2:0] step_ff, step_in;
   logic       quad_ff;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] ptr_ff, ptr_in;
   logic [HASH_BITS-1:0]  clear_ff, clear_in;
   corner_rsp_type res_ff, res_in;
   corner_rsp_type out_ff;
   logic rsp_valid_ff, rsp_valid_in;

   triple_type cur;
   logic [1:0] sel;
   logic [HASH_BITS-1:0] bucket, hw_addr;
   logic [COUNT_BITS-1:0] hw_data;
   entry_type rd_entry, wr_entry;
   triple_type rd_tri;
   logic [COUNT_BITS-1:0] rd_next, hd_data, chase;
   logic rd_en, hd_en, wr_en, hw_en, last, chase_ok, out_free, accept;

   always_comb begin
      unique case (step_ff)
         3'd0: sel = 2'd0; 3'd1: sel = 2'd1; 3'd2: sel = 2'd2;
         3'd3: sel = 2'd3; 3'd4: sel = 2'd0; 3'd5: sel = 2'd2;
         default: sel = 2'd0;
      endcase
   end
   assign cur      = corner_ff[sel];
   assign bucket   = hash_triple(cur);
   assign last     = quad_ff ? (step_ff == 3'd5) : (step_ff == 3'd2);
   assign rd_tri   = rd_entry.key;
   assign rd_next  = rd_entry.next;
   assign chase    = (state_ff == S_HEAD) ? hd_data : rd_next;
   assign chase_ok = chase < count_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign accept   = req_valid && req_ready;
   assign wr_entry = '{key: cur, next: hd_data};
   assign hw_addr  = (state_ff == S_CLEAR) ? clear_ff : bucket;
   assign hw_data  = (state_ff == S_CLEAR) ? LINK_END : count_ff;

   mvdi_table u_table (
      .clock(clock), .rd_en(rd_en), .rd_addr(ptr_in[ADDR_BITS-1:0]),
      .rd_entry(rd_entry), .hd_en(hd_en), .hd_addr(bucket),
      .hd_data(hd_data), .wr_en(wr_en), .wr_addr(count_ff[ADDR_BITS-1:0]),
      .wr_entry(wr_entry), .hw_en(hw_en), .hw_addr(hw_addr), .hw_data(hw_data)
   );

   always_comb begin
      state_in = state_ff; step_in = step_ff; count_in = count_ff;
      ptr_in = ptr_ff; clear_in = clear_ff; res_in = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_en = 1'b0; hd_en = 1'b0; wr_en = 1'b0; hw_en = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            hw_en = 1'b1; clear_in = clear_ff + 1'b1;
            if (clear_ff == HASH_BITS'(HASH_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: if (req_valid) begin
            step_in = 3'd0; state_in = S_ISSUE;
         end
         S_ISSUE: begin
            hd_en = 1'b1; state_in = S_HEAD;
         end
         S_HEAD, S_WALK: begin
            res_in.key = cur; res_in.last_corner = last;
            if (state_ff == S_WALK && rd_tri == cur) begin
               res_in.vertex_index = ptr_ff[VIDX_BITS-1:0];
               res_in.is_new = 1'b0; res_in.table_full = 1'b0;
               state_in = S_OUT;
            end else if (chase_ok) begin
               ptr_in = chase; rd_en = 1'b1; state_in = S_WALK;
            end else if (count_ff < TABLE_COUNT) begin
               wr_en = 1'b1; hw_en = 1'b1;
               res_in.vertex_index = count_ff[VIDX_BITS-1:0];
               res_in.is_new = 1'b1; res_in.table_full = 1'b0;
               count_in = count_ff + 1'b1; state_in = S_OUT;
            end else begin
               res_in.vertex_index = '0;
               res_in.is_new = 1'b0; res_in.table_full = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: if (out_free) begin
            rsp_valid_in = 1'b1;
            if (last) state_in = S_IDLE;
            else begin
               step_in = step_ff + 1'b1; state_in = S_ISSUE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; count_ff <= '0; rsp_valid_ff <= 1'b0; step_ff <= '0;
         clear_ff <= '0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; rsp_valid_ff <= rsp_valid_in;
         step_ff <= step_in; clear_ff <= clear_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      res_ff <= res_in;
      if (state_ff == S_OUT && out_free) out_ff <= res_ff;
      if (accept) begin
         corner_ff[0] <= '{req_pos_a, req_tex_a, req_nrm_a};
         corner_ff[1] <= '{req_pos_b, req_tex_b, req_nrm_b};
         corner_ff[2] <= '{req_pos_c, req_tex_c, req_nrm_c};
         corner_ff[3] <= '{req_pos_d, req_tex_d, req_nrm_d};
         quad_ff <= (req_pos_d != '0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = out_ff.vertex_index;
   assign rsp_is_new       = out_ff.is_new;
   assign rsp_out_pos      = out_ff.key.pos;
   assign rsp_out_tex      = out_ff.key.tex;
   assign rsp_out_nrm      = out_ff.key.nrm;
   assign rsp_table_full   = out_ff.table_full;
   assign rsp_last_corner  = out_ff.last_corner;
endmodule
`default_nettype wire
